### design/iccp_pkg.sv
// ----------------------------------------------------------------------------
// Inline color code parser package
// Shared types, byte codes, the named color table and the hex digit decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package iccp_pkg;

  // Default color stack depth.
  localparam int ICCP_STACK_DEPTH = 16;

  // Field widths of the stream payloads.
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 32;
  localparam int DATA_W  = CHAR_W + COLOR_W;

  // Bytes with a meaning inside the text.
  localparam logic [7:0] ESC_BYTE  = 8'h07;
  localparam logic [7:0] CH_POP    = 8'h78;  // x
  localparam logic [7:0] CH_HASH   = 8'h23;  // #
  localparam logic [7:0] CH_DASH   = 8'h2D;  // -

  localparam logic [31:0] INIT_COLOR = 32'hFFF0F0F0;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [1:0] {
    PH_TEXT,
    PH_ESC,
    PH_DASH,
    PH_HEX
  } phase_t;

  // Request from the parser to the color stack.
  typedef struct packed {
    logic        clear;
    logic        push;
    logic        pop;
    logic [31:0] color;
  } stack_cmd_t;

  // What the stack tells the parser.
  typedef struct packed {
    logic        under_ok;  // at least two entries stacked
    logic [31:0] under;     // entry just below the top
    logic        overflow;  // sticky, a push found the stack full
  } stack_stat_t;

  // Returns {hit, color} for one of the ten letter colors.
  function automatic logic [32:0] named_color(input logic [7:0] letter, input logic dark);
    logic [32:0] res;
    res = '0;
    case (letter)
      "y":     res = {1'b1, dark ? 32'hFF009999 : 32'hFF00FFFF};
      "o":     res = {1'b1, dark ? 32'hFF006699 : 32'hFF0099FF};
      "g":     res = {1'b1, dark ? 32'hFF009900 : 32'hFF00FF00};
      "u":     res = {1'b1, dark ? 32'hFF990000 : 32'hFFFF0000};
      "r":     res = {1'b1, dark ? 32'hFF000099 : 32'hFF0000FF};
      "t":     res = {1'b1, dark ? 32'hFF999900 : 32'hFFFFFF00};
      "b":     res = {1'b1, 32'hFF000000};
      "m":     res = {1'b1, dark ? 32'hFF990099 : 32'hFFFF00FF};
      "p":     res = {1'b1, dark ? 32'hFF990066 : 32'hFFFF0099};
      "w":     res = {1'b1, dark ? 32'hFF999999 : 32'hFFFFFFFF};
      default: res = '0;
    endcase
    return res;
  endfunction

  // Returns {bad, nibble}; a byte that is no hex digit gives bad with a zero nibble.
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] res;
    res = '0;
    case (b) inside
      [8'h30:8'h39]:                res = {1'b0, b[3:0]};
      [8'h41:8'h46], [8'h61:8'h66]: res = {1'b0, b[3:0] + 4'd9};
      default:                      res = {1'b1, 4'd0};
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

### design/iccp_stack.sv
// ----------------------------------------------------------------------------
// Color stack
// Stack of colors in a memory, with the entry below the top kept at hand so
// that a pop in every cycle finds the color it restores.
// ----------------------------------------------------------------------------
`default_nettype none

module iccp_stack
  import iccp_pkg::*;
#(
  parameter int DEPTH = ICCP_STACK_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire stack_cmd_t  cmd,
  output stack_stat_t      stat
);

  localparam int LW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);

  logic [31:0]   mem [DEPTH];
  logic [LW-1:0] level;
  logic          overflow;
  logic [31:0]   top;
  logic [31:0]   under_reg;
  logic [31:0]   rd_data;
  logic          use_rd;

  logic          full;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [LW-1:0] rd_level;
  logic [31:0]   under;

  assign full     = (level == LW'(DEPTH));
  assign wr_en    = cmd.push && !cmd.clear;
  assign wr_addr  = full ? AW'(DEPTH - 1) : level[AW-1:0];
  // After a pop the new "under" entry sits three below the old level.
  assign rd_level = level - LW'(3);
  assign rd_addr  = rd_level[AW-1:0];
  assign under    = use_rd ? rd_data : under_reg;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd.color;
    end
    if (cmd.pop && !cmd.clear) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level    <= '0;
      overflow <= 1'b0;
      use_rd   <= 1'b0;
    end else if (cmd.clear) begin
      level    <= '0;
      overflow <= 1'b0;
    end else if (cmd.push) begin
      if (full) begin
        overflow <= 1'b1;
      end else begin
        level  <= level + LW'(1);
        use_rd <= 1'b0;
      end
    end else if (cmd.pop) begin
      if (level != '0) begin
        level <= level - LW'(1);
      end
      use_rd <= 1'b1;
    end
  end

  // Top and below-top values; meaningful only at the stack levels that use them.
  always_ff @(posedge clk) begin
    if (!cmd.clear && cmd.push) begin
      top <= cmd.color;
      if (!full) begin
        under_reg <= top;
      end
    end else if (!cmd.clear && cmd.pop) begin
      top <= under;
    end
  end

  assign stat.under_ok = (level >= LW'(2));
  assign stat.under    = under;
  assign stat.overflow = overflow;

endmodule

`default_nettype wire

### design/inline_color_code_parser.sv
// ----------------------------------------------------------------------------
// Inline color code parser
// Turns a byte stream of text with inline color codes into colored characters.
// ----------------------------------------------------------------------------
// Usage:
// The input stream carries one text byte per request: s_tdata holds the byte
// and the line default color, and s_tuser marks the first byte of a line,
// which clears the color stack and loads the default. Escape byte 0x07 opens
// a code (pop with x, #RRGGBB, an optional dash and a color letter); codes are
// consumed without producing output. Every plain byte leaves on the output
// stream as one request with its ABGR color and the sticky stack overflow flag.
// Throughput is one request per cycle on both sides while the receiver is
// ready. Each result is registered; the whole parse and the stack access
// happen in the cycle its byte is accepted, and the stack memory keeps the
// entry below the top prefetched so back-to-back pops cause no stall.
// If the receiver stalls, one result waits in the output register and one
// more in a skid register; s_tready drops only while the skid register is
// full. Reset empties the output side, puts the parser in text mode with
// color 0xFFF0F0F0 and an empty stack. The stack memory needs no clearing
// pass: only entries written in the current line are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module inline_color_code_parser
  import iccp_pkg::*;
#(
  parameter int STACK_DEPTH = ICCP_STACK_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [DATA_W-1:0] s_tdata,   // char_byte [7:0], line_default [39:8]
  input  wire logic              s_tuser,   // first_of_line [0]
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [DATA_W-1:0]      m_tdata,   // out_char [7:0], out_color [39:8]
  output logic                   m_tuser    // stack_overflow [0]
);

  // Input fields.
  logic [7:0]  char_byte;
  logic [31:0] line_default;
  logic        first_of_line;
  logic        s_fire;

  assign char_byte     = s_tdata[CHAR_W-1:0];
  assign line_default  = s_tdata[DATA_W-1:CHAR_W];
  assign first_of_line = s_tuser;
  assign s_fire        = s_tvalid && s_tready;

  // Parser state.
  phase_t      phase, phase_next;
  logic [2:0]  hex_count, hex_count_next;
  logic [23:0] hex_value, hex_value_next;
  logic [2:0]  hex_bad, hex_bad_next;
  logic [31:0] current_color, current_color_next;
  logic [31:0] default_color, default_color_next;

  stack_cmd_t  stk_cmd;
  stack_stat_t stk_stat;

  // A line start overrides the state the previous line left behind.
  phase_t      phase_eff;
  logic [31:0] cur_eff;
  logic [31:0] def_eff;
  logic [4:0]  digit;
  logic [32:0] named;
  logic [31:0] hex_color;
  logic        produce;
  logic [DATA_W-1:0] res_data;
  logic        res_user;

  assign phase_eff = first_of_line ? PH_TEXT : phase;
  assign cur_eff   = first_of_line ? line_default : current_color;
  assign def_eff   = first_of_line ? line_default : default_color;
  assign digit     = hex_digit(char_byte);
  assign named     = named_color(char_byte, phase_eff == PH_DASH);

  // Color of a finished #RRGGBB code. A bad digit saturates its byte and all
  // higher bytes of the ABGR word.
  always_comb begin
    hex_color = {ALPHA_OPAQUE, hex_value_next[7:0], hex_value_next[15:8],
                 hex_value_next[23:16]};
    if (hex_bad_next[0]) begin
      hex_color = '1;
    end
    if (hex_bad_next[1]) begin
      hex_color = hex_color | 32'hFFFFFF00;
    end
    if (hex_bad_next[2]) begin
      hex_color = hex_color | 32'hFFFF0000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_TEXT;
      hex_count     <= '0;
      hex_value     <= '0;
      hex_bad       <= '0;
      current_color <= INIT_COLOR;
      default_color <= INIT_COLOR;
    end else begin
      phase         <= phase_next;
      hex_count     <= hex_count_next;
      hex_value     <= hex_value_next;
      hex_bad       <= hex_bad_next;
      current_color <= current_color_next;
      default_color <= default_color_next;
    end
  end

  always_comb begin
    phase_next          = phase;
    hex_count_next      = hex_count;
    hex_value_next      = hex_value;
    hex_bad_next        = hex_bad;
    current_color_next  = current_color;
    default_color_next  = default_color;
    stk_cmd             = '0;
    produce             = 1'b0;

    if (s_fire) begin
      current_color_next = cur_eff;
      default_color_next = def_eff;
      stk_cmd.clear      = first_of_line;

      case (phase_eff)
        PH_ESC: begin
          phase_next = PH_TEXT;
          if (char_byte == CH_POP) begin
            stk_cmd.pop        = 1'b1;
            current_color_next = stk_stat.under_ok ? stk_stat.under : def_eff;
          end else if (char_byte == CH_HASH) begin
            hex_count_next = '0;
            hex_value_next = '0;
            hex_bad_next   = '0;
            phase_next     = PH_HEX;
          end else if (char_byte == CH_DASH) begin
            phase_next = PH_DASH;
          end else begin
            stk_cmd.push       = 1'b1;
            stk_cmd.color      = named[32] ? named[31:0] : def_eff;
            current_color_next = stk_cmd.color;
          end
        end
        PH_DASH: begin
          phase_next         = PH_TEXT;
          stk_cmd.push       = 1'b1;
          stk_cmd.color      = named[32] ? named[31:0] : def_eff;
          current_color_next = stk_cmd.color;
        end
        PH_HEX: begin
          // Digit pair k (red, green, blue) flags bit k when it holds a bad digit.
          if (digit[4]) begin
            hex_bad_next = hex_bad | (3'b001 << hex_count[2:1]);
          end
          hex_value_next = {hex_value[19:0], digit[3:0]};
          hex_count_next = hex_count + 3'd1;
          if (hex_count == 3'd5) begin
            stk_cmd.push       = 1'b1;
            stk_cmd.color      = hex_color;
            current_color_next = hex_color;
            hex_count_next     = '0;
            phase_next         = PH_TEXT;
          end
        end
        default: begin
          phase_next = PH_TEXT;
          if (char_byte == ESC_BYTE) begin
            phase_next = PH_ESC;
          end else begin
            produce = 1'b1;
          end
        end
      endcase
    end
  end

  iccp_stack #(
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .rst  (rst),
    .cmd  (stk_cmd),
    .stat (stk_stat)
  );

  assign res_data = {cur_eff, char_byte};
  assign res_user = first_of_line ? 1'b0 : stk_stat.overflow;

  // Output register plus skid register.
  logic              skid_valid;
  logic [DATA_W-1:0] skid_data;
  logic              skid_user;
  logic              load_from_skid;
  logic              load_main;
  logic              load_skid;

  assign s_tready       = !skid_valid;
  assign load_from_skid = skid_valid && m_tready;
  assign load_main      = !skid_valid && s_fire && produce && (!m_tvalid || m_tready);
  assign load_skid      = !skid_valid && s_fire && produce && m_tvalid && !m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (load_from_skid) begin
        skid_valid <= 1'b0;
      end else if (load_main) begin
        m_tvalid <= 1'b1;
      end else if (load_skid) begin
        skid_valid <= 1'b1;
      end else if (!skid_valid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_from_skid) begin
      m_tdata <= skid_data;
      m_tuser <= skid_user;
    end else if (load_main) begin
      m_tdata <= res_data;
      m_tuser <= res_user;
    end
    if (load_skid) begin
      skid_data <= res_data;
      skid_user <= res_user;
    end
  end

  // A waiting skid entry always sits behind a valid output register.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid register holds a result while the output register is empty");

  // A line start clears the overflow flag for the bytes that follow.
  a_line_clears_overflow: assert property (@(posedge clk) disable iff (rst)
    (s_fire && first_of_line) |=> !stk_stat.overflow)
    else $error("overflow flag survived a line start");

  // A plain byte taken while the output side is free shows up in the next cycle.
  a_result_latency: assert property (@(posedge clk) disable iff (rst)
    (s_fire && produce && !m_tvalid) |=> (m_tvalid && m_tdata == $past(res_data)))
    else $error("plain byte did not reach the output register");

  // Codes never produce output.
  a_code_silent: assert property (@(posedge clk) disable iff (rst)
    (s_fire && phase_eff != PH_TEXT && !m_tvalid && !skid_valid) |=> !m_tvalid)
    else $error("a color code produced an output request");

endmodule

`default_nettype wire

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inline color code parser testbench
// Sends a table of hand-picked bytes and then randomly built text lines with
// color codes, predicts every colored character, and checks each result in
// order while both sides of the stream idle at random outside a calm stretch.
// ----------------------------------------------------------------------------

module tb_top;
  import iccp_pkg::*;

  localparam int DEPTH       = ICCP_STACK_DEPTH;
  localparam int DIR_N       = 28;
  localparam int RAND_ITEMS  = 700;
  localparam int CALM_FROM   = DIR_N + 150;  // no idling on either side from here ...
  localparam int CALM_TO     = DIR_N + 300;  // ... up to here
  localparam int HOLD_AT     = DIR_N + 350;  // second point where the sender drains
  localparam int DRAIN_WAIT  = 16;
  localparam int STALL_LIMIT = 1000;

  // One byte request for the input stream. The typed fields carry a
  // hand-written expectation for the few table rows where it is obvious.
  typedef struct packed {
    logic [7:0]  ch;
    logic        sol;
    logic [31:0] dflt;
    logic        typed;
    logic [7:0]  t_ch;
    logic [31:0] t_color;
    logic        t_ovf;
  } byte_req_t;

  // One colored character as it leaves the parser.
  typedef struct packed {
    logic [7:0]  ch;
    logic [31:0] color;
    logic        ovf;
  } glyph_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata = '0;   // char_byte [7:0], line_default [39:8]
  logic              s_tuser = 1'b0; // first_of_line [0]
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;        // out_char [7:0], out_color [39:8]
  logic              m_tuser;        // stack_overflow [0]

  inline_color_code_parser #(
    .STACK_DEPTH(DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  byte_req_t dir_tab [DIR_N];
  byte_req_t byte_q [$];     // every byte request of the run, in send order
  glyph_t    glyph_q [$];    // colored characters still to come out
  int        sent = 0;       // byte requests accepted so far
  int        mismatches = 0;
  int        idle_cycles = 0;
  bit        drained = 1'b0;

  // Stimulus builder state: the next byte added opens a line when set.
  bit          sol_pending;
  logic [31:0] sol_color;

  // Parser shadow state.
  phase_t      phase;
  int          hex_cnt;
  logic [23:0] hex_acc;
  logic [2:0]  hex_err;
  logic [31:0] cur_color;
  logic [31:0] line_color;
  logic [31:0] stk [DEPTH];
  int          stk_lvl;
  bit          ovf;

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic logic [31:0] letter_color(input logic [7:0] b, input bit dark,
                                               input logic [31:0] dflt);
    case (b)
      "y": return dark ? 32'hFF009999 : 32'hFF00FFFF;
      "o": return dark ? 32'hFF006699 : 32'hFF0099FF;
      "g": return dark ? 32'hFF009900 : 32'hFF00FF00;
      "u": return dark ? 32'hFF990000 : 32'hFFFF0000;
      "r": return dark ? 32'hFF000099 : 32'hFF0000FF;
      "t": return dark ? 32'hFF999900 : 32'hFFFFFF00;
      "b": return 32'hFF000000;
      "m": return dark ? 32'hFF990099 : 32'hFFFF00FF;
      "p": return dark ? 32'hFF990066 : 32'hFFFF0099;
      "w": return dark ? 32'hFF999999 : 32'hFFFFFFFF;
      default: return dflt;  // an unknown letter falls back to the line default
    endcase
  endfunction

  // A full stack keeps its level and overwrites the top entry.
  task automatic push_color(input logic [31:0] c);
    if (stk_lvl < DEPTH) begin
      stk[stk_lvl] = c;
      stk_lvl++;
    end else begin
      stk[DEPTH-1] = c;
      ovf = 1'b1;
    end
    cur_color = c;
  endtask

  // Walks one byte through the shadow parser; emit tells whether it prints.
  task automatic parse_byte(input logic [7:0] b, input logic sol, input logic [31:0] dflt,
                            output bit emit, output glyph_t g);
    logic [3:0]  nib;
    bit          bad;
    logic [31:0] c;
    emit = 1'b0;
    g = '0;
    if (sol) begin
      line_color = dflt;
      cur_color  = dflt;
      stk_lvl    = 0;
      ovf        = 1'b0;
      phase      = PH_TEXT;  // an unfinished code from the last line is dropped
    end
    case (phase)
      PH_ESC: begin
        if (b == CH_POP) begin
          if (stk_lvl > 0) stk_lvl--;
          cur_color = (stk_lvl > 0) ? stk[stk_lvl-1] : line_color;
          phase = PH_TEXT;
        end else if (b == CH_HASH) begin
          hex_cnt = 0;
          hex_acc = '0;
          hex_err = '0;
          phase   = PH_HEX;
        end else if (b == CH_DASH) begin
          phase = PH_DASH;
        end else begin
          push_color(letter_color(b, 1'b0, line_color));
          phase = PH_TEXT;
        end
      end
      PH_DASH: begin
        push_color(letter_color(b, 1'b1, line_color));
        phase = PH_TEXT;
      end
      PH_HEX: begin
        bad = 1'b0;
        if (b >= "0" && b <= "9") nib = 4'(b - "0");
        else if (b >= "A" && b <= "F") nib = 4'(b - "A" + 10);
        else if (b >= "a" && b <= "f") nib = 4'(b - "a" + 10);
        else begin
          nib = 4'd0;
          bad = 1'b1;
        end
        // Digits come as RRGGBB, so two digits per component.
        if (bad) hex_err[hex_cnt >> 1] = 1'b1;
        hex_acc = {hex_acc[19:0], nib};
        hex_cnt++;
        if (hex_cnt >= 6) begin
          c = {ALPHA_OPAQUE, hex_acc[7:0], hex_acc[15:8], hex_acc[23:16]};
          // A bad component forces itself and every higher byte to all ones.
          if (hex_err[0]) c = '1;
          if (hex_err[1]) c[31:8] = '1;
          if (hex_err[2]) c[31:16] = '1;
          push_color(c);
          hex_cnt = 0;
          phase = PH_TEXT;
        end
      end
      default: begin
        phase = PH_TEXT;
        if (b == ESC_BYTE) begin
          phase = PH_ESC;
        end else begin
          emit = 1'b1;
          g = '{b, cur_color, ovf};
        end
      end
    endcase
  endtask

  task automatic add_byte(input logic [7:0] b);
    byte_req_t r;
    r = '0;
    r.ch   = b;
    r.sol  = sol_pending;
    r.dflt = sol_pending ? sol_color : 32'($urandom);  // ignored unless a line starts
    sol_pending = 1'b0;
    byte_q.insert(byte_q.size(), r);
  endtask

  function automatic logic [7:0] pick_digit();
    string good;
    string junk;
    good = "0123456789ABCDEFabcdef";
    junk = "GgZz@/:[~ x#-";
    if ($urandom_range(0, 99) < 85) return good[$urandom_range(0, good.len() - 1)];
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
    return junk[$urandom_range(0, junk.len() - 1)];
  endfunction

  function automatic logic [7:0] pick_letter();
    string known;
    known = "yogurtbmpw";
    if ($urandom_range(0, 99) < 85) return known[$urandom_range(0, known.len() - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  // Builds the directed table and then random lines. Most random lines are
  // well-formed text with codes; some are push storms that fill the stack,
  // and a share of codes is broken or cut off by the next line start.
  initial begin
    int          n_tok;
    int          kind;
    int          sub;
    int          n_dig;
    bit          storm;
    bit          cut;
    logic [7:0]  b;

    dir_tab = '{
      // plain byte straight after reset takes the reset color
      '{8'h41, 1'b0, 32'h0, 1'b1, 8'h41, 32'hFFF0F0F0, 1'b0},
      // zero byte opening a line with an all-zero default
      '{8'h00, 1'b1, 32'h0, 1'b1, 8'h00, 32'h00000000, 1'b0},
      '{8'hFF, 1'b0, 32'h0, 1'b1, 8'hFF, 32'h00000000, 1'b0},
      // hex color with a bad green digit
      '{ESC_BYTE, 1'b0, 32'h0, 1'b0, 8'h0, 32'h0, 1'b0},
      '{CH_HASH,  1'b0, 32'h0, 1'b0, 8'h0, 32'h0, 1'b0},
      '{8'h31, 1'b0, 32'h0, 1'b0, 8'h0, 32'h0, 1'b0},
      '{8'h61, 1'b0, 32'h0, 1'b0, 8'h0, 32'h0, 1'b0},
      '{8'h46, 1'b0, 32'h0, 1'b0, 8'h0, 32'h0, 1'b0},
      '{8'h47, 1'b0, 32'h0, 1'b0, 8'h0, 32'h0, 1'b0},
      '{8'h30, 1'b0, 32'h0, 1'b0, 8'h0, 32'h0, 1'b0},
      '{8'h39, 1'b0, 32'h0, 1'b0, 8'h0, 32'h0, 1'b0},
      '{8'h6B, 1'b0, 32'h0, 1'b0, 8'h0, 32'h0, 1'b0},
      // dark yellow
      '{ESC_BYTE, 1'b0, 32'h0, 1'b0, 8'h0, 32'h0, 1'b0},
      '{CH_DASH,  1'b0, 32'h0, 1'b0, 8'h0, 32'h0, 1'b0},
      '{8'h79, 1'b0, 32'h0, 1'b0, 8'h0, 32'h0, 1'b0},
      // escape right after escape counts as an unknown letter
      '{ESC_BYTE, 1'b0, 32'h0, 1'b0, 8'h0, 32'h0, 1'b0},
      '{ESC_BYTE, 1'b0, 32'h0, 1'b0, 8'h0, 32'h0, 1'b0},
      '{8'h73, 1'b0, 32'h0, 1'b0, 8'h0, 32'h0, 1'b0},
      // pop back to dark yellow
      '{ESC_BYTE, 1'b0, 32'h0, 1'b0, 8'h0, 32'h0, 1'b0},
      '{CH_POP,   1'b0, 32'h0, 1'b0, 8'h0, 32'h0, 1'b0},
      '{8'h6D, 1'b0, 32'h0, 1'b0, 8'h0, 32'h0, 1'b0},
      // hex code left unfinished when the next line starts
      '{ESC_BYTE, 1'b0, 32'h0, 1'b0, 8'h0, 32'h0, 1'b0},
      '{CH_HASH,  1'b0, 32'h0, 1'b0, 8'h0, 32'h0, 1'b0},
      '{8'h35, 1'b0, 32'h0, 1'b0, 8'h0, 32'h0, 1'b0},
      '{8'h51, 1'b1, 32'hFFFFFFFF, 1'b1, 8'h51, 32'hFFFFFFFF, 1'b0},
      // pop on an empty stack keeps the line default
      '{ESC_BYTE, 1'b0, 32'h0, 1'b0, 8'h0, 32'h0, 1'b0},
      '{CH_POP,   1'b0, 32'h0, 1'b0, 8'h0, 32'h0, 1'b0},
      '{8'h65, 1'b0, 32'h0, 1'b1, 8'h65, 32'hFFFFFFFF, 1'b0}
    };
    foreach (dir_tab[i]) byte_q.insert(byte_q.size(), dir_tab[i]);

    sol_pending = 1'b0;
    sol_color   = '0;
    while (byte_q.size() < DIR_N + RAND_ITEMS) begin
      sub = $urandom_range(0, 7);
      sol_color   = (sub == 0) ? 32'h0 : (sub == 1) ? 32'hFFFFFFFF : 32'($urandom);
      sol_pending = 1'b1;
      storm = ($urandom_range(0, 7) == 0);
      n_tok = storm ? $urandom_range(24, 34) : $urandom_range(3, 12);
      cut   = 1'b0;
      for (int t = 0; t < n_tok && !cut; t++) begin
        if (storm) begin
          // mostly pushes with a character now and then, a few pops at the end
          if (t >= n_tok - 3) kind = 80;
          else if (t % 3 == 2) kind = 0;
          else kind = $urandom_range(40, 76);
        end else begin
          kind = $urandom_range(0, 99);
        end
        if (kind < 40) begin
          if ($urandom_range(0, 99) < 80) b = 8'($urandom_range(8'h20, 8'h7E));
          else b = 8'($urandom_range(0, 255));
          if (b == ESC_BYTE) b = 8'h08;
          add_byte(b);
        end else if (kind < 55) begin
          add_byte(ESC_BYTE);
          add_byte(pick_letter());
        end else if (kind < 65) begin
          add_byte(ESC_BYTE);
          add_byte(CH_DASH);
          add_byte(pick_letter());
        end else if (kind < 77) begin
          add_byte(ESC_BYTE);
          add_byte(CH_HASH);
          for (int d = 0; d < 6; d++) add_byte(pick_digit());
        end else if (kind < 90) begin
          add_byte(ESC_BYTE);
          add_byte(CH_POP);
        end else if (kind < 95) begin
          sub = $urandom_range(0, 3);
          add_byte(ESC_BYTE);
          case (sub)
            0: add_byte(8'($urandom_range(0, 255)));
            1: begin
              // x, # or escape after the dash are unknown letters
              add_byte(CH_DASH);
              n_dig = $urandom_range(0, 2);
              add_byte(n_dig == 0 ? CH_POP : n_dig == 1 ? CH_HASH : ESC_BYTE);
            end
            2: begin
              add_byte(CH_HASH);
              n_dig = $urandom_range(0, 5);
              for (int d = 0; d < n_dig; d++) add_byte(pick_digit());
              cut = 1'b1;
            end
            default: cut = 1'b1;
          endcase
        end else begin
          add_byte(8'($urandom_range(0, 255)));
        end
      end
    end

    wait (drained);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Stream side of the bench: predicts each accepted byte request, checks
  // each accepted result request against the oldest prediction, and then
  // chooses what both sides drive for the next cycle. Doing all of it in one
  // process keeps the queue counts seen by the sender exact.
  always @(posedge clk) begin : stream_side
    byte_req_t r;
    glyph_t    g;
    bit        emit;
    bit        quiet;
    bit        hold;
    bit        calm;
    if (rst) begin
      phase       = PH_TEXT;
      hex_cnt     = 0;
      hex_acc     = '0;
      hex_err     = '0;
      cur_color   = INIT_COLOR;
      line_color  = INIT_COLOR;
      stk_lvl     = 0;
      ovf         = 1'b0;
      s_tvalid    <= 1'b0;
      m_tready    <= 1'b0;
      idle_cycles <= 0;
    end else begin
      quiet = 1'b1;
      if (s_tvalid && s_tready) begin
        r = byte_q[sent];
        parse_byte(r.ch, r.sol, r.dflt, emit, g);
        if (emit) begin
          if (r.typed) g = '{r.t_ch, r.t_color, r.t_ovf};
          glyph_q.insert(glyph_q.size(), g);
        end
        sent++;
        quiet = 1'b0;
      end
      if (m_tvalid && m_tready) begin
        quiet = 1'b0;
        if (glyph_q.size() == 0) begin
          flag_mismatch($sformatf("result char %h color %h with nothing expected",
                                  m_tdata[7:0], m_tdata[39:8]));
        end else begin
          g = glyph_q.pop_front();
          if (m_tdata[7:0] !== g.ch)
            flag_mismatch($sformatf("out_char %h, expected %h", m_tdata[7:0], g.ch));
          if (m_tdata[39:8] !== g.color)
            flag_mismatch($sformatf("out_color %h, expected %h for char %h",
                                    m_tdata[39:8], g.color, g.ch));
          if (m_tuser !== g.ovf)
            flag_mismatch($sformatf("stack_overflow %b, expected %b for char %h",
                                    m_tuser, g.ovf, g.ch));
        end
      end
      idle_cycles <= quiet ? idle_cycles + 1 : 0;
      drained     <= (sent == byte_q.size()) && (glyph_q.size() == 0);

      // After the table and once more in the random part, the sender holds
      // off until every predicted character has come out.
      hold = ((sent == DIR_N) || (sent == HOLD_AT)) && (glyph_q.size() != 0);
      calm = (sent >= CALM_FROM) && (sent < CALM_TO);

      // A pending request stays on the bus until it is taken.
      if (!s_tvalid || s_tready) begin
        if (sent < byte_q.size() && !hold && (calm || $urandom_range(0, 99) >= 24)) begin
          r = byte_q[sent];
          s_tvalid <= 1'b1;
          s_tdata  <= {r.dflt, r.ch};
          s_tuser  <= r.sol;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= calm || ($urandom_range(0, 99) >= 24);
    end
  end

  // Ends a run in which nothing moves for too long.
  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

endmodule

### filelist.f
design/iccp_pkg.sv
design/iccp_stack.sv
design/inline_color_code_parser.sv
tb/tb_top.sv
